>>> hw/rtl/trapezoid_motion_profile_top_macros.svh
// Assertion macros for the trapezoid motion profile block.
// Used by the top level only; expects clk and rst in scope.
`ifndef TRAPEZOID_MOTION_PROFILE_TOP_MACROS_SVH
`define TRAPEZOID_MOTION_PROFILE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TZP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TZP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TZP_ASSERT_IMP(lbl, ante, cons, msg)
`define TZP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/tzp_pkg.sv
// Shared types and constants of the trapezoid motion profile block.
// No dependencies.
`default_nettype none
package tzp_pkg;
  localparam int TIME_FRAC_BITS_DEF = 16;
  localparam int TIME_W     = 24;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int QUO_W      = 32;
  localparam int DIVISOR_W  = 16;
  localparam int ROOT_W     = 32;
  localparam int RADICAND_W = 64;
  localparam int AMT_MAX_W  = 48;
  localparam int ACC_W      = 17;
  localparam int FREQ_W     = 28;
  localparam int MICROSTEPS = 32;
  localparam int FULL_STEPS = 200;
  localparam int SCREW_LEAD = 2;
  localparam int STEP_SCALE = MICROSTEPS * FULL_STEPS / SCREW_LEAD;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_DISTANCE = 2'd2;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic                   triangle;
    logic [AMT_MAX_W-1:0]   amt;
  } d1_side_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] vel;
    logic [31:0] pos;
  } d2_side_t;
endpackage
`default_nettype wire

>>> hw/rtl/trapezoid_motion_profile_top.sv
// Trapezoid motion profile evaluator, top level.
// Depends on tzp_pkg, tzp_div, tzp_sqrt and the macros header.
//
// Usage: write max_accel, speed_limit and move_distance through cfg_we,
// cfg_index, cfg_data while no transaction is in flight. Each input
// transaction on s_* carries a time point; each output transaction on m_*
// carries position, velocity, acceleration, step frequency and phase.
// Throughput: one transaction per cycle while the receiver does not stall.
// The path runs through the two 32-stage dividers (the first one runs beside
// a 32-stage square root for the triangular peak speed).
// The whole pipeline moves on one enable; when the receiver stalls with a
// result at the output register, every stage holds and s_tready drops.
// Reset (synchronous) clears the valid bits and loads the register
// defaults: accel 40, speed 30, distance 0.
`default_nettype none
module trapezoid_motion_profile_top #(
  parameter int TIME_FRAC_BITS = tzp_pkg::TIME_FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [23:0]  s_tdata,   // time_point[23:0]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [111:0]      m_tdata,   // position[31:0], velocity[63:32],
                                       // acceleration[80:64], step_freq[108:81]
  output logic [1:0]        m_tuser    // phase[1:0]
);
  import tzp_pkg::*;
  `include "trapezoid_motion_profile_top_macros.svh"

  localparam int LAT  = 6 + 2 * QUO_W;
  localparam int AMTW = 56 - TIME_FRAC_BITS;
  localparam int D1W  = 73 - TIME_FRAC_BITS;

  logic [CFG_W-1:0] max_accel, speed_limit, move_distance;
  logic [CFG_W-1:0] am, vm, pf;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_accel     <= 16'd40;
      speed_limit   <= 16'd30;
      move_distance <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ACCEL:     max_accel     <= cfg_data;
        REG_SPEED_LIMIT:   speed_limit   <= cfg_data;
        REG_MOVE_DISTANCE: move_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  assign am = (max_accel == '0) ? CFG_W'(1) : max_accel;
  assign vm = (speed_limit == '0) ? CFG_W'(1) : speed_limit;
  assign pf = move_distance;

  logic en;
  logic [LAT-1:0] vld;
  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // stage 1
  logic [TIME_W-1:0] t1;
  logic [39:0]       at1, tv1;
  logic [31:0]       pam1, vv1;
  always_ff @(posedge clk) begin
    if (en) begin
      t1   <= s_tdata[TIME_W-1:0];
      at1  <= 40'(am) * 40'(s_tdata[TIME_W-1:0]);
      tv1  <= 40'(vm) * 40'(s_tdata[TIME_W-1:0]);
      pam1 <= 32'(pf) * 32'(am);
      vv1  <= 32'(vm) * 32'(vm);
    end
  end

  // stage 2
  logic [55:0]     atv2;
  logic [63:0]     att2;
  logic            c0_2, c1_2, trap2;
  logic [AMTW-1:0] amt2;
  logic [31:0]     pam2, vv2;
  always_ff @(posedge clk) begin
    if (en) begin
      atv2  <= 56'(at1) * 56'(vm);
      att2  <= 64'(at1) * 64'(t1);
      c0_2  <= 41'(at1) <= (41'(vm) << TIME_FRAC_BITS);
      c1_2  <= 41'(tv1) <= (41'(pf) << TIME_FRAC_BITS);
      trap2 <= pam1 > vv1;
      amt2  <= AMTW'((64'(at1) << 16) >> TIME_FRAC_BITS);
      pam2  <= pam1;
      vv2   <= vv1;
    end
  end

  // stage 3: phase decision and first dividend
  logic [57:0]      lim, nval, mval;
  logic [65:0]      tl;
  logic [79:0]      xn, xm;
  phase_t           ph_c;
  logic [D1W-1:0]   dvd_c;
  logic [CFG_W-1:0] dvs_c;

  always_comb begin
    lim  = (58'(pam2) + 58'(vv2)) << TIME_FRAC_BITS;
    tl   = 66'(pf) << (2 * TIME_FRAC_BITS);
    nval = (58'(atv2) << 1) - (58'(vv2) << TIME_FRAC_BITS);
    mval = lim - 58'(atv2);
    xn   = (80'(nval) << 15) >> TIME_FRAC_BITS;
    xm   = (80'(mval) << 16) >> TIME_FRAC_BITS;
    priority if (pf == '0) begin
      ph_c = PH_DONE;
    end else if (trap2) begin
      priority if (c0_2)                 ph_c = PH_ACCEL;
      else if (c1_2)                     ph_c = PH_CRUISE;
      else if (58'(atv2) <= lim)         ph_c = PH_DECEL;
      else                               ph_c = PH_DONE;
    end else begin
      priority if (66'(att2) < tl)       ph_c = PH_ACCEL;
      else if (66'(att2) <= (tl << 2))   ph_c = PH_DECEL;
      else                               ph_c = PH_DONE;
    end
    dvd_c = '0;
    dvs_c = am;
    if (trap2 && ph_c == PH_CRUISE) begin
      dvd_c = D1W'(xn);
    end else if (trap2 && ph_c == PH_DECEL) begin
      dvd_c = D1W'(xm);
      dvs_c = vm;
    end
  end

  d1_side_t         side3;
  logic [D1W-1:0]   dvd3;
  logic [CFG_W-1:0] dvs3;
  logic [31:0]      pam3;
  always_ff @(posedge clk) begin
    if (en) begin
      side3.phase    <= ph_c;
      side3.triangle <= !trap2;
      side3.amt      <= AMT_MAX_W'(amt2);
      dvd3           <= dvd_c;
      dvs3           <= dvs_c;
      pam3           <= pam2;
    end
  end

  logic [QUO_W-1:0]    q1;
  logic [ROOT_W-1:0]   peak;
  logic [$bits(d1_side_t)-1:0] side1_raw;
  d1_side_t            side1;

  tzp_div #(.DW(D1W), .SW($bits(d1_side_t))) u_div1 (
    .clk      (clk),
    .en       (en),
    .dvd      (dvd3),
    .dvs      (dvs3),
    .side_in  (side3),
    .quo      (q1),
    .side_out (side1_raw)
  );

  tzp_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand ({pam3, 32'd0}),
    .root     (peak)
  );

  assign side1 = d1_side_t'(side1_raw);

  // stage 5: velocity
  logic [48:0] twop, amtx, vtri;
  logic [31:0] vel_c, pos_c;
  always_comb begin
    twop  = 49'(peak) << 1;
    amtx  = 49'(side1.amt);
    vtri  = (twop > amtx) ? twop - amtx : '0;
    vel_c = '0;
    pos_c = q1;
    unique case (side1.phase)
      PH_ACCEL:  vel_c = (amtx > 49'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : amtx[31:0];
      PH_CRUISE: vel_c = {vm, 16'd0};
      PH_DECEL: begin
        if (side1.triangle) begin
          vel_c = (vtri > 49'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : vtri[31:0];
        end else begin
          vel_c = q1;
        end
      end
      PH_DONE:   vel_c = '0;
    endcase
  end

  d2_side_t side5, side6;
  logic [63:0] sq6;
  always_ff @(posedge clk) begin
    if (en) begin
      side5.phase <= side1.phase;
      side5.vel   <= vel_c;
      side5.pos   <= pos_c;
      sq6         <= 64'(side5.vel) * 64'(side5.vel);
      side6       <= side5;
    end
  end

  logic [QUO_W-1:0] q2;
  logic [$bits(d2_side_t)-1:0] side2_raw;
  d2_side_t side2;

  tzp_div #(.DW(47), .SW($bits(d2_side_t))) u_div2 (
    .clk      (clk),
    .en       (en),
    .dvd      (sq6[63:17]),
    .dvs      (am),
    .side_in  (side6),
    .quo      (q2),
    .side_out (side2_raw)
  );

  assign side2 = d2_side_t'(side2_raw);

  // output stage
  logic [31:0]       full, pos_o;
  logic [ACC_W-1:0]  acc_o;
  logic [FREQ_W-1:0] step_o;
  always_comb begin
    full   = {pf, 16'd0};
    step_o = FREQ_W'(32'(side2.vel[31:16]) * 32'(STEP_SCALE));
    unique case (side2.phase)
      PH_ACCEL: begin
        pos_o = q2;
        acc_o = ACC_W'(am);
      end
      PH_CRUISE: begin
        pos_o = side2.pos;
        acc_o = '0;
      end
      PH_DECEL: begin
        pos_o = (q2 >= full) ? '0 : full - q2;
        acc_o = ACC_W'(0) - ACC_W'(am);
      end
      PH_DONE: begin
        pos_o = full;
        acc_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {3'd0, step_o, acc_o, side2.vel, pos_o};
      m_tuser <= side2.phase;
    end
  end

  logic done_rest, cruise_ok;
  assign done_rest = (m_tdata[80:32] == '0);
  assign cruise_ok = (m_tdata[63:48] == vm) && (m_tdata[47:32] == '0) &&
                     (m_tdata[80:64] == '0);

  `TZP_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, $stable(vld), "pipeline moved in stall")
  `TZP_ASSERT_IMP(a_done_rest, m_tvalid && m_tuser == PH_DONE, done_rest, "done not at rest")
  `TZP_ASSERT_IMP(a_cruise_vel, m_tvalid && m_tuser == PH_CRUISE, cruise_ok, "cruise speed wrong")
endmodule
`default_nettype wire

>>> hw/rtl/tzp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on tzp_pkg.
`default_nettype none
module tzp_div #(
  parameter int DW = 48,
  parameter int SW = 8
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [DW-1:0]               dvd,
  input  wire logic [tzp_pkg::DIVISOR_W-1:0] dvs,
  input  wire logic [SW-1:0]               side_in,
  output logic [tzp_pkg::QUO_W-1:0]        quo,
  output logic [SW-1:0]                    side_out
);
  import tzp_pkg::*;
  localparam int RW = (DW > DIVISOR_W + QUO_W) ? DW : DIVISOR_W + QUO_W;

  logic [RW-1:0]        rem_in  [QUO_W];
  logic [QUO_W-1:0]     quo_in  [QUO_W];
  logic [DIVISOR_W-1:0] dvs_in  [QUO_W];
  logic [SW-1:0]        side_i  [QUO_W];
  logic [RW-1:0]        rem_q   [QUO_W];
  logic [QUO_W-1:0]     quo_q   [QUO_W];
  logic [DIVISOR_W-1:0] dvs_q   [QUO_W];
  logic [SW-1:0]        side_q  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [RW-1:0] trial;
    if (k == 0) begin : g_first
      assign rem_in[k] = RW'(dvd);
      assign quo_in[k] = '0;
      assign dvs_in[k] = dvs;
      assign side_i[k] = side_in;
    end else begin : g_rest
      assign rem_in[k] = rem_q[k-1];
      assign quo_in[k] = quo_q[k-1];
      assign dvs_in[k] = dvs_q[k-1];
      assign side_i[k] = side_q[k-1];
    end
    assign trial = RW'(dvs_in[k]) << (QUO_W - 1 - k);

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in[k] >= trial) begin
          rem_q[k] <= rem_in[k] - trial;
          quo_q[k] <= quo_in[k] | (QUO_W'(1) << (QUO_W - 1 - k));
        end else begin
          rem_q[k] <= rem_in[k];
          quo_q[k] <= quo_in[k];
        end
        dvs_q[k]  <= dvs_in[k];
        side_q[k] <= side_i[k];
      end
    end
  end

  assign quo      = quo_q[QUO_W-1];
  assign side_out = side_q[QUO_W-1];
endmodule
`default_nettype wire

>>> hw/rtl/tzp_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on tzp_pkg.
`default_nettype none
module tzp_sqrt (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [tzp_pkg::RADICAND_W-1:0] radicand,
  output logic [tzp_pkg::ROOT_W-1:0]         root
);
  import tzp_pkg::*;

  logic [RADICAND_W-1:0] x_in [ROOT_W];
  logic [RADICAND_W-1:0] r_in [ROOT_W];
  logic [RADICAND_W-1:0] x_q  [ROOT_W];
  logic [RADICAND_W-1:0] r_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [RADICAND_W-1:0] bitv;
    logic [RADICAND_W-1:0] sum;
    if (k == 0) begin : g_first
      assign x_in[k] = radicand;
      assign r_in[k] = '0;
    end else begin : g_rest
      assign x_in[k] = x_q[k-1];
      assign r_in[k] = r_q[k-1];
    end
    assign bitv = RADICAND_W'(1) << (RADICAND_W - 2 - 2 * k);
    assign sum  = r_in[k] + bitv;

    always_ff @(posedge clk) begin
      if (en) begin
        if (x_in[k] >= sum) begin
          x_q[k] <= x_in[k] - sum;
          r_q[k] <= (r_in[k] >> 1) + bitv;
        end else begin
          x_q[k] <= x_in[k];
          r_q[k] <= r_in[k] >> 1;
        end
      end
    end
  end

  assign root = r_q[ROOT_W-1][ROOT_W-1:0];
endmodule
`default_nettype wire
